### design/swsr_pkg.sv
package swsr_pkg;

    // Fixed port widths of the block
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 3;

    // Default sizes
    localparam int DEF_DEPTH      = 64;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_SEARCH = 3'd2,
        OP_EDIT   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

endpackage

### design/swsr_mem.sv
module swsr_mem #(
    parameter int DEPTH      = swsr_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = swsr_pkg::DEF_DATA_WIDTH,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] store_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/swsr_ctrl.sv
module swsr_ctrl #(
    parameter int DEPTH      = swsr_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = swsr_pkg::DEF_DATA_WIDTH,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [swsr_pkg::OP_W-1:0]     op,
    input  logic [swsr_pkg::VALUE_W-1:0]  value,
    input  logic [swsr_pkg::VALUE_W-1:0]  new_value,
    output logic                          done,
    output logic [swsr_pkg::STATUS_W-1:0] status,
    output logic                          found,
    output logic                          top_valid,
    output logic [swsr_pkg::VALUE_W-1:0]  top_value,
    output logic [swsr_pkg::COUNT_W-1:0]  count,
    // memory port
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [DATA_WIDTH-1:0]         mem_wdata,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_raddr,
    input  logic [DATA_WIDTH-1:0]         mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TOP
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         fill_reg;
    logic                  done_reg;
    swsr_pkg::op_t         op_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] repl_reg;
    logic [DATA_WIDTH-1:0] top_reg;
    logic [AW-1:0]         rd_addr_reg;
    swsr_pkg::status_t     status_reg;
    logic                  found_reg;

    logic                  accept;
    swsr_pkg::op_t         op_in;
    logic [DATA_WIDTH-1:0] key_in;
    logic [DATA_WIDTH-1:0] repl_in;
    logic                  full;
    logic                  empty;
    logic [AW-1:0]         top_addr;
    logic                  hit;

    assign accept   = start && (state_reg == S_IDLE);
    assign op_in    = swsr_pkg::op_t'(op);
    assign key_in   = DATA_WIDTH'(value);
    assign repl_in  = DATA_WIDTH'(new_value);
    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign top_addr = AW'(fill_reg - CW'(1));
    assign hit      = (mem_rdata == key_reg);

    // memory port drive
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = key_in;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        swsr_pkg::OP_PUSH:
                        begin
                            mem_we    = !full;
                            mem_waddr = AW'(fill_reg);
                        end
                        swsr_pkg::OP_POP:
                        begin
                            mem_re    = (fill_reg >= CW'(2));
                            mem_raddr = AW'(fill_reg - CW'(2));
                        end
                        swsr_pkg::OP_SEARCH, swsr_pkg::OP_EDIT:
                        begin
                            mem_re    = !empty;
                            mem_raddr = top_addr;
                        end
                        default:
                        begin
                            mem_re = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    mem_we    = (op_reg == swsr_pkg::OP_EDIT);
                    mem_waddr = rd_addr_reg;
                    mem_wdata = repl_reg;
                end
                else if (rd_addr_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_addr_reg - AW'(1);
                end
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= op_in;
                        key_reg    <= key_in;
                        repl_reg   <= repl_in;
                        status_reg <= swsr_pkg::ST_OK;
                        found_reg  <= 1'b0;
                        done_reg   <= 1'b1;
                        case (op_in)
                            swsr_pkg::OP_PUSH:
                            begin
                                if (full)
                                begin
                                    status_reg <= swsr_pkg::ST_FULL;
                                end
                                else
                                begin
                                    top_reg  <= key_in;
                                    fill_reg <= fill_reg + CW'(1);
                                end
                            end
                            swsr_pkg::OP_POP:
                            begin
                                if (empty)
                                begin
                                    status_reg <= swsr_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    fill_reg <= fill_reg - CW'(1);
                                    // new top comes from memory
                                    if (fill_reg >= CW'(2))
                                    begin
                                        done_reg  <= 1'b0;
                                        state_reg <= S_TOP;
                                    end
                                end
                            end
                            swsr_pkg::OP_SEARCH, swsr_pkg::OP_EDIT:
                            begin
                                if (empty)
                                begin
                                    if (op_in == swsr_pkg::OP_EDIT)
                                    begin
                                        status_reg <= swsr_pkg::ST_MISS;
                                    end
                                end
                                else
                                begin
                                    done_reg    <= 1'b0;
                                    rd_addr_reg <= top_addr;
                                    state_reg   <= S_SCAN;
                                end
                            end
                            swsr_pkg::OP_CLEAR:
                            begin
                                fill_reg <= '0;
                            end
                            default:
                            begin
                                status_reg <= swsr_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                        if (op_reg == swsr_pkg::OP_EDIT && rd_addr_reg == top_addr)
                        begin
                            top_reg <= repl_reg;
                        end
                    end
                    else if (rd_addr_reg == '0)
                    begin
                        // bottom reached, no match
                        if (op_reg == swsr_pkg::OP_EDIT)
                        begin
                            status_reg <= swsr_pkg::ST_MISS;
                        end
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        rd_addr_reg <= rd_addr_reg - AW'(1);
                    end
                end
                S_TOP:
                begin
                    top_reg   <= mem_rdata;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign top_valid = !empty;
    assign top_value = empty ? '0 : swsr_pkg::VALUE_W'(top_reg);
    assign count     = swsr_pkg::COUNT_W'(fill_reg);

endmodule

### design/stack_with_search_replace_top.sv
// LIFO stack of data words with search and replace-first-match.
//
// Command channel: drive op/value/new_value with start high; the word is
// taken at a rising edge where start is high and busy is low. Ops: push,
// pop, search, edit (replace first match from the top), clear.
// Result channel: done pulses for one cycle with status, found, top_valid,
// top_value and count; the receiver must take it then, there is no stall.
//
// Command timing (one command at a time, one result per command):
//   push, clear, refused ops, unused codes: result the cycle after accept;
//     a new command may be taken in that same result cycle (1 cycle/word).
//   pop: timed as push when no word is left below; otherwise the new top is
//     fetched through the memory read port and loaded in S_TOP with the result.
//   search/edit: the single read port of the stack memory scans one entry
//     per cycle from the top down, comparing 1..DEPTH entries in S_SCAN;
//     busy stays high, so no new command is taken until the scan ends.
// Reset: stack empty, idle. Memory contents are not cleared; entries at or
// above the fill count are never read.
module stack_with_search_replace_top #(
    parameter int DEPTH      = swsr_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = swsr_pkg::DEF_DATA_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [swsr_pkg::OP_W-1:0]     op,
    input  logic [swsr_pkg::VALUE_W-1:0]  value,
    input  logic [swsr_pkg::VALUE_W-1:0]  new_value,
    output logic                          done,
    output logic [swsr_pkg::STATUS_W-1:0] status,
    output logic                          found,
    output logic                          top_valid,
    output logic [swsr_pkg::VALUE_W-1:0]  top_value,
    output logic [swsr_pkg::COUNT_W-1:0]  count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // memory port between controller and stack store
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    swsr_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value     (value),
        .new_value (new_value),
        .done      (done),
        .status    (status),
        .found     (found),
        .top_valid (top_valid),
        .top_value (top_value),
        .count     (count),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    swsr_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // results only come out while idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an empty stack reports a zero top word
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        !top_valid |-> (top_value == '0))
        else $error("nonzero top word on empty stack");

    // push and clear report done in the next cycle
    a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == swsr_pkg::OP_PUSH || op == swsr_pkg::OP_CLEAR))
        |=> done)
        else $error("push/clear result missing");

    // no second result without a new command
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !start) |=> !done)
        else $error("extra result strobe");

    // a refused pop leaves the stack empty
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == swsr_pkg::ST_EMPTY) |-> (!top_valid && count == '0))
        else $error("pop refusal with words held");

endmodule
